@@ hw/rtl/ncs_pkg.sv @@
// shared constants, types and helper function of the nearest-centroid search
package ncs_pkg;

    // sizing of the centroid store
    localparam int CELLS_MAX  = 16;
    localparam int DIM_MAX    = 16;
    localparam int ADDR_LIMIT = 16;

    localparam int CELL_LIMIT = (CELLS_MAX < ADDR_LIMIT) ? CELLS_MAX : ADDR_LIMIT;
    localparam int DIM_LIMIT  = (DIM_MAX < ADDR_LIMIT) ? DIM_MAX : ADDR_LIMIT;

    localparam int CELL_IDX_W   = (CELL_LIMIT > 1) ? $clog2(CELL_LIMIT) : 1;
    localparam int TABLE_DEPTH  = CELLS_MAX * DIM_MAX;
    localparam int TABLE_ADDR_W = $clog2(TABLE_DEPTH);

    // field and datapath widths
    localparam int CELL_W    = 4;
    localparam int COMP_W    = 4;
    localparam int VALUE_W   = 16;
    localparam int MAG_W     = 16;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int SUM_W     = 37;
    localparam int DIST_W    = 36;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    // request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIM_IN_USE   = 1'b0,
        REG_CELLS_IN_USE = 1'b1
    } cfg_reg_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic                  load_we;
        logic                  query_start;
        logic                  issue;
        logic [CELL_IDX_W-1:0] issue_cell;
        logic                  finish;
    } ncs_cmd_t;

    // force a register value into 1..limit
    function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] value,
                                                   input logic [CFG_W-1:0] limit);
        logic [CFG_W-1:0] res;
        if (value == '0) begin
            res = CFG_W'(1);
        end
        else if (value > limit) begin
            res = limit;
        end
        else begin
            res = value;
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/ncs_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
module ncs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

@@ hw/rtl/ncs_dp.sv @@
// datapath: centroid store, distance pipeline, partial sums and result register
module ncs_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ncs_pkg::ncs_cmd_t             cmd,
    input  logic [ncs_pkg::CELL_W-1:0]    cell_index,
    input  logic [ncs_pkg::COMP_W-1:0]    component_index,
    input  logic signed [ncs_pkg::VALUE_W-1:0] component_value,
    output logic                          pipe_busy,
    output logic [ncs_pkg::CELL_W-1:0]    nearest_cell,
    output logic [ncs_pkg::DIST_W-1:0]    min_distance
);

    localparam int AW = ncs_pkg::TABLE_ADDR_W;
    localparam int CW = ncs_pkg::CELL_IDX_W;

    // query word held for the whole scan
    logic signed [ncs_pkg::VALUE_W-1:0] q_reg;
    logic [ncs_pkg::COMP_W-1:0]         comp_reg;

    // pipeline stage registers
    logic                       v1_reg, v2_reg, v3_reg;
    logic [CW-1:0]              cell1_reg, cell2_reg, cell3_reg;
    logic [ncs_pkg::MAG_W-1:0]  mag_reg;
    logic [ncs_pkg::SQ_W-1:0]   sq_reg;

    // partial sums and running minimum
    logic [ncs_pkg::SUM_W-1:0]  psum_reg [ncs_pkg::CELL_LIMIT];
    logic [ncs_pkg::SUM_W-1:0]  best_sum_reg;
    logic [CW-1:0]              best_cell_reg;

    logic [ncs_pkg::CELL_W-1:0] nearest_reg;
    logic [ncs_pkg::DIST_W-1:0] dist_reg;

    logic                          load_ok;
    logic [AW-1:0]                 waddr;
    logic [AW-1:0]                 raddr;
    logic [ncs_pkg::VALUE_W-1:0]   rdata;
    logic signed [ncs_pkg::VALUE_W:0] diff;
    logic [ncs_pkg::VALUE_W:0]     diff_abs;
    logic [ncs_pkg::SUM_W:0]       sum_wide;
    logic [ncs_pkg::SUM_W-1:0]     sum_sat;

    // store addressing: row per centroid, column per component
    assign load_ok = cmd.load_we
                     && (32'(cell_index) < ncs_pkg::CELLS_MAX)
                     && (32'(component_index) < ncs_pkg::DIM_MAX);
    assign waddr = AW'(cell_index) * AW'(ncs_pkg::DIM_MAX) + AW'(component_index);
    assign raddr = AW'(cmd.issue_cell) * AW'(ncs_pkg::DIM_MAX) + AW'(comp_reg);

    ncs_ram #(
        .WIDTH(ncs_pkg::VALUE_W),
        .DEPTH(ncs_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (load_ok),
        .waddr (waddr),
        .wdata (component_value),
        .re    (cmd.issue),
        .raddr (raddr),
        .rdata (rdata)
    );

    // absolute difference of query and centroid component
    assign diff     = {q_reg[ncs_pkg::VALUE_W-1], q_reg}
                      - $signed({rdata[ncs_pkg::VALUE_W-1], rdata});
    assign diff_abs = diff[ncs_pkg::VALUE_W] ? ($unsigned(-diff)) : $unsigned(diff);

    // saturating accumulate
    assign sum_wide = {1'b0, psum_reg[cell3_reg]} + (ncs_pkg::SUM_W + 1)'(sq_reg);
    assign sum_sat  = sum_wide[ncs_pkg::SUM_W] ? '1 : sum_wide[ncs_pkg::SUM_W-1:0];

    assign pipe_busy = v1_reg | v2_reg | v3_reg;

    // query capture
    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
        begin
            q_reg    <= component_value;
            comp_reg <= component_index;
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage payload: difference magnitude, then square
    always_ff @(posedge clk)
    begin
        cell1_reg <= cmd.issue_cell;
        cell2_reg <= cell1_reg;
        cell3_reg <= cell2_reg;
        mag_reg   <= diff_abs[ncs_pkg::MAG_W-1:0];
        sq_reg    <= mag_reg * mag_reg;
    end

    // partial sums, cleared after each finished query
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ncs_pkg::CELL_LIMIT; i++)
            begin
                psum_reg[i] <= '0;
            end
        end
        else if (cmd.finish)
        begin
            for (int i = 0; i < ncs_pkg::CELL_LIMIT; i++)
            begin
                psum_reg[i] <= '0;
            end
        end
        else if (v3_reg)
        begin
            psum_reg[cell3_reg] <= sum_sat;
        end
    end

    // running minimum, lowest index wins ties
    always_ff @(posedge clk)
    begin
        if (v3_reg && ((cell3_reg == '0) || (sum_sat < best_sum_reg)))
        begin
            best_sum_reg  <= sum_sat;
            best_cell_reg <= cell3_reg;
        end
    end

    // result word register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            nearest_reg <= ncs_pkg::CELL_W'(best_cell_reg);
            dist_reg    <= best_sum_reg[ncs_pkg::SUM_W-1] ? '1
                           : best_sum_reg[ncs_pkg::DIST_W-1:0];
        end
    end

    assign nearest_cell = nearest_reg;
    assign min_distance = dist_reg;

endmodule

@@ hw/rtl/ncs_ctrl.sv @@
// controller: accepts words, sequences the centroid scan, owns the result valid
module ncs_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         req_type,
    input  logic [ncs_pkg::COMP_W-1:0]   component_index,
    input  logic [ncs_pkg::CFG_W-1:0]    dims,
    input  logic [ncs_pkg::CFG_W-1:0]    cells,
    output logic                         out_valid,
    input  logic                         out_ready,
    input  logic                         pipe_busy,
    output ncs_pkg::ncs_cmd_t            cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    state_t                          state_reg, state_next;
    logic [ncs_pkg::CELL_IDX_W-1:0]  cnt_reg, cnt_next;
    logic                            final_reg, final_next;
    logic                            out_valid_reg, out_valid_next;

    logic accept;
    logic is_query;
    logic comp_ok;
    logic comp_last;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign is_query  = (req_type == ncs_pkg::REQ_QUERY);
    assign comp_ok   = ncs_pkg::CFG_W'(component_index) < dims;
    assign comp_last = ncs_pkg::CFG_W'(component_index) == (dims - ncs_pkg::CFG_W'(1));

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        final_next      = final_reg;
        out_valid_next  = out_valid_reg;
        cmd             = '0;
        cmd.issue_cell  = cnt_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !is_query)
                begin
                    cmd.load_we = 1'b1;
                end
                if (accept && is_query && comp_ok)
                begin
                    cmd.query_start = 1'b1;
                    final_next      = comp_last;
                    cnt_next        = '0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (ncs_pkg::CFG_W'(cnt_reg) == (cells - ncs_pkg::CFG_W'(1)))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    if (!final_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (!out_valid_reg || out_ready)
                    begin
                        cmd.finish     = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ hw/rtl/nearest_centroid_search.sv @@
// Top level: nearest-centroid search, configuration registers and glue.
// Load word: written while idle, so the next word can follow in the next cycle.
// Query word: input not ready until back in idle, one centroid per cycle through the
//   single read port of the centroid memory, then magnitude, square and sum stages.
//   Only the last component yields a result, once drained and the old result is taken.
// Reset clears control, partial sums and sets both registers to 16; memory is undefined.
module nearest_centroid_search (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic [ncs_pkg::CELL_W-1:0]        cell_index,
    input  logic [ncs_pkg::COMP_W-1:0]        component_index,
    input  logic signed [ncs_pkg::VALUE_W-1:0] component_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ncs_pkg::CELL_W-1:0]        nearest_cell,
    output logic [ncs_pkg::DIST_W-1:0]        min_distance,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ncs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ncs_pkg::CFG_W-1:0]         cfg_data
);

    logic [ncs_pkg::CFG_W-1:0] dim_reg, dim_next;
    logic [ncs_pkg::CFG_W-1:0] cells_reg, cells_next;
    logic [ncs_pkg::CFG_W-1:0] dims_eff;
    logic [ncs_pkg::CFG_W-1:0] cells_eff;
    ncs_pkg::ncs_cmd_t         cmd;
    logic                      pipe_busy;

    assign cfg_ready = 1'b1;

    // configuration register writes
    always_comb
    begin
        dim_next   = dim_reg;
        cells_next = cells_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (ncs_pkg::cfg_reg_t'(cfg_index))
                ncs_pkg::REG_DIM_IN_USE:   dim_next   = cfg_data;
                ncs_pkg::REG_CELLS_IN_USE: cells_next = cfg_data;
                default:                   dim_next   = dim_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg   <= ncs_pkg::CFG_RESET;
            cells_reg <= ncs_pkg::CFG_RESET;
        end
        else
        begin
            dim_reg   <= dim_next;
            cells_reg <= cells_next;
        end
    end

    // effective counts within the supported range
    assign dims_eff  = ncs_pkg::clamp_cfg(dim_reg, ncs_pkg::CFG_W'(ncs_pkg::DIM_LIMIT));
    assign cells_eff = ncs_pkg::clamp_cfg(cells_reg, ncs_pkg::CFG_W'(ncs_pkg::CELL_LIMIT));

    ncs_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .component_index (component_index),
        .dims            (dims_eff),
        .cells           (cells_eff),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pipe_busy       (pipe_busy),
        .cmd             (cmd)
    );

    ncs_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cell_index      (cell_index),
        .component_index (component_index),
        .component_value (component_value),
        .pipe_busy       (pipe_busy),
        .nearest_cell    (nearest_cell),
        .min_distance    (min_distance)
    );

endmodule

@@ hw/rtl/ncs_checker.sv @@
// port-level checks for the nearest-centroid search, bound to the top level
module ncs_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              req_type,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [ncs_pkg::CELL_W-1:0]        nearest_cell,
    input logic [ncs_pkg::DIST_W-1:0]        min_distance,
    input logic                              cfg_ready
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(nearest_cell)
                                    && $stable(min_distance))
        else $error("result word changed while stalled");

    // the input stays ready after a load word
    a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (req_type == ncs_pkg::REQ_LOAD) |=> in_ready)
        else $error("input not ready after a load word");

    // a result only appears at the end of a scan, never while idle
    a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result raised without a preceding scan");

    // configuration port never back-pressures
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind nearest_centroid_search ncs_checker u_ncs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .nearest_cell (nearest_cell),
    .min_distance (min_distance),
    .cfg_ready    (cfg_ready)
);

@@ tb/ncs_result_checker.sv @@
// checker for the nearest-centroid search: tracks the centroids, predicts and compares results
module ncs_result_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic                               req_type,
    input  logic [ncs_pkg::CELL_W-1:0]         cell_index,
    input  logic [ncs_pkg::COMP_W-1:0]         component_index,
    input  logic signed [ncs_pkg::VALUE_W-1:0] component_value,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [ncs_pkg::CELL_W-1:0]         nearest_cell,
    input  logic [ncs_pkg::DIST_W-1:0]         min_distance,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [ncs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ncs_pkg::CFG_W-1:0]          cfg_data,
    output int                                 fail_count,
    output int                                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ncs_pkg::CELL_W-1:0] cell_id;
        logic [ncs_pkg::DIST_W-1:0] distance;
    } nearest_t;

    localparam logic [ncs_pkg::SUM_W-1:0]  SUM_SAT  = '1;
    localparam logic [ncs_pkg::DIST_W-1:0] DIST_SAT = '1;

    // mirror of the block state
    logic signed [ncs_pkg::VALUE_W-1:0] codebook [ncs_pkg::CELLS_MAX][ncs_pkg::DIM_MAX];
    logic [ncs_pkg::SUM_W-1:0]          dist_acc [16];
    logic [ncs_pkg::CFG_W-1:0]          dim_reg;
    logic [ncs_pkg::CFG_W-1:0]          cells_reg;
    nearest_t                           nearest_due [$];
    nearest_t                           want;
    int                                 errors = 0;

    // register value as the block uses it: zero acts as one, large values stop at the limit
    function automatic int unsigned in_use(input logic [ncs_pkg::CFG_W-1:0] v,
                                           input int unsigned lim);
        int unsigned res;
        if (v == '0) begin
            res = 1;
        end
        else if (v > lim) begin
            res = lim;
        end
        else begin
            res = 32'(v);
        end
        return res;
    endfunction

    // add one query component to every distance in use, pick the winner on the last one
    task automatic accumulate_query(input logic [ncs_pkg::COMP_W-1:0] comp,
                                    input logic signed [ncs_pkg::VALUE_W-1:0] q);
        int unsigned                dims;
        int unsigned                cells;
        int unsigned                best_cell;
        longint signed              diff;
        longint unsigned            total;
        logic [ncs_pkg::SUM_W-1:0]  best_sum;
        nearest_t                   res;
        dims  = in_use(dim_reg, ncs_pkg::DIM_LIMIT);
        cells = in_use(cells_reg, ncs_pkg::CELL_LIMIT);
        if (comp >= dims) begin
            return;
        end
        for (int c = 0; c < cells; c++) begin
            diff = longint'(q) - longint'(codebook[c][comp]);
            if (diff < 0) begin
                diff = -diff;
            end
            total = longint'(dist_acc[c]) + longint'(diff * diff);
            dist_acc[c] = (total > SUM_SAT) ? SUM_SAT : total[ncs_pkg::SUM_W-1:0];
        end
        if (comp != dims - 1) begin
            return;
        end
        // lowest index wins a tie
        best_cell = 0;
        best_sum  = dist_acc[0];
        for (int c = 1; c < cells; c++) begin
            if (dist_acc[c] < best_sum) begin
                best_sum  = dist_acc[c];
                best_cell = c;
            end
        end
        for (int c = 0; c < 16; c++) begin
            dist_acc[c] = '0;
        end
        res.cell_id  = best_cell[ncs_pkg::CELL_W-1:0];
        res.distance = (best_sum > ncs_pkg::SUM_W'(DIST_SAT)) ? DIST_SAT
                       : best_sum[ncs_pkg::DIST_W-1:0];
        nearest_due.insert(nearest_due.size(), res);
    endtask

    // watch all three channels
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            dim_reg   = ncs_pkg::CFG_RESET;
            cells_reg = ncs_pkg::CFG_RESET;
            for (int c = 0; c < 16; c++) begin
                dist_acc[c] = '0;
            end
            nearest_due.delete();
            pending    <= 0;
            fail_count <= errors;
        end
        else begin
            // result word against the oldest prediction
            if (out_valid && out_ready) begin
                if (nearest_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result word: expected none, actual cell %0d dist %0d",
                             $time, nearest_cell, min_distance);
                end
                else begin
                    want = nearest_due.pop_front();
                    if (nearest_cell !== want.cell_id) begin
                        errors++;
                        $display("%0t: nearest_cell mismatch: expected %0d, actual %0d",
                                 $time, want.cell_id, nearest_cell);
                    end
                    if (min_distance !== want.distance) begin
                        errors++;
                        $display("%0t: min_distance mismatch: expected %0d, actual %0d",
                                 $time, want.distance, min_distance);
                    end
                end
            end
            // input word, under the register values held before this edge
            if (in_valid && in_ready) begin
                if (req_type == ncs_pkg::REQ_LOAD) begin
                    codebook[cell_index][component_index] = component_value;
                end
                else begin
                    accumulate_query(component_index, component_value);
                end
            end
            // register write
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    ncs_pkg::REG_DIM_IN_USE:   dim_reg   = cfg_data;
                    ncs_pkg::REG_CELLS_IN_USE: cells_reg = cfg_data;
                    default: ;
                endcase
            end
            pending    <= nearest_due.size();
            fail_count <= errors;
        end
    end

endmodule

@@ tb/nearest_centroid_search_tb.sv @@
// testbench top for the nearest-centroid search: clock, reset, stimulus and verdict
module nearest_centroid_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = ncs_pkg::CELLS_MAX + 24;
    localparam int HOLD_CYCLES  = 400;

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_ready;
    logic                               req_type;
    logic [ncs_pkg::CELL_W-1:0]         cell_index;
    logic [ncs_pkg::COMP_W-1:0]         component_index;
    logic signed [ncs_pkg::VALUE_W-1:0] component_value;
    logic                               out_valid;
    logic                               out_ready;
    logic [ncs_pkg::CELL_W-1:0]         nearest_cell;
    logic [ncs_pkg::DIST_W-1:0]         min_distance;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [ncs_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [ncs_pkg::CFG_W-1:0]          cfg_data;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int unsigned dims_now;
    bit          calm;
    bit          hold_req;
    bit          hold_done;

    nearest_centroid_search DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .cell_index      (cell_index),
        .component_index (component_index),
        .component_value (component_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .nearest_cell    (nearest_cell),
        .min_distance    (min_distance),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    ncs_result_checker u_result_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .cell_index      (cell_index),
        .component_index (component_index),
        .component_value (component_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .nearest_cell    (nearest_cell),
        .min_distance    (min_distance),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off
    initial
    begin
        out_ready <= 1'b0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= calm || ($urandom_range(99) >= 13);
        end
    end

    // component value biased toward the extremes and zero
    function automatic logic [ncs_pkg::VALUE_W-1:0] pick_value();
        logic [ncs_pkg::VALUE_W-1:0] v;
        case ($urandom_range(7))
            0:       v = 16'h8000;
            1:       v = 16'h7FFF;
            2:       v = 16'h0000;
            default: v = ncs_pkg::VALUE_W'($urandom);
        endcase
        return v;
    endfunction

    // offer one input word and wait for its acceptance
    task automatic send_word(input logic kind, input logic [ncs_pkg::CELL_W-1:0] cell_id,
                             input logic [ncs_pkg::COMP_W-1:0] comp,
                             input logic [ncs_pkg::VALUE_W-1:0] value);
        while (!calm && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        req_type        <= kind;
        cell_index      <= cell_id;
        component_index <= comp;
        component_value <= value;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_query(input logic [ncs_pkg::COMP_W-1:0] comp,
                              input logic [ncs_pkg::VALUE_W-1:0] value);
        send_word(ncs_pkg::REQ_QUERY, ncs_pkg::CELL_W'($urandom), comp, value);
    endtask

    // drain: nothing outstanding, then let a busy query finish
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write, valid left high for a following write
    task automatic write_reg(input ncs_pkg::cfg_reg_t idx, input logic [ncs_pkg::CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic set_config(input logic [ncs_pkg::CFG_W-1:0] dims,
                              input logic [ncs_pkg::CFG_W-1:0] cells);
        wait_idle();
        write_reg(ncs_pkg::REG_DIM_IN_USE, dims);
        write_reg(ncs_pkg::REG_CELLS_IN_USE, cells);
        cfg_valid <= 1'b0;
        dims_now  = (dims == 0) ? 1
                    : ((dims > ncs_pkg::DIM_LIMIT) ? ncs_pkg::DIM_LIMIT : dims);
    endtask

    // stimulus and verdict
    initial
    begin
        int unsigned                 count;
        int unsigned                 roll;
        logic [ncs_pkg::COMP_W-1:0]  comp;
        in_valid        <= 1'b0;
        req_type        <= ncs_pkg::REQ_LOAD;
        cell_index      <= '0;
        component_index <= '0;
        component_value <= '0;
        cfg_valid       <= 1'b0;
        cfg_index       <= ncs_pkg::REG_DIM_IN_USE;
        cfg_data        <= '0;
        rst_n           <= 1'b0;
        dims_now  = ncs_pkg::DIM_LIMIT;
        calm      = 1'b0;
        hold_req  = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole centroid table so no query reads an empty entry
        for (int c = 0; c < ncs_pkg::CELLS_MAX; c++)
        begin
            for (int d = 0; d < ncs_pkg::DIM_MAX; d++)
            begin
                send_word(ncs_pkg::REQ_LOAD, ncs_pkg::CELL_W'(c), ncs_pkg::COMP_W'(d),
                          pick_value());
            end
        end

        // short vectors with extreme values
        set_config(5'd3, 5'd16);
        send_query(4'd0, 16'h7FFF);
        send_query(4'd1, 16'h8000);
        send_query(4'd2, 16'h0000);
        // index past the vector length is dropped, repeats and gaps still accumulate
        send_query(4'd15, 16'h1234);
        send_query(4'd0, pick_value());
        send_query(4'd0, pick_value());
        send_query(4'd2, pick_value());
        // zero and oversized register values
        set_config(5'd0, 5'd31);
        send_query(4'd0, pick_value());
        send_query(4'd5, pick_value());
        // registers change between the two halves of one query
        set_config(5'd17, 5'd1);
        send_query(4'd0, pick_value());
        set_config(5'd2, 5'd0);
        send_query(4'd1, pick_value());
        // two identical centroids far from the query: tie and saturation
        set_config(5'd2, 5'd2);
        send_word(ncs_pkg::REQ_LOAD, 4'd0, 4'd0, 16'h8000);
        send_word(ncs_pkg::REQ_LOAD, 4'd1, 4'd0, 16'h8000);
        send_word(ncs_pkg::REQ_LOAD, 4'd0, 4'd1, 16'h7FFF);
        send_word(ncs_pkg::REQ_LOAD, 4'd1, 4'd1, 16'h7FFF);
        repeat (17) send_query(4'd0, 16'h7FFF);
        send_query(4'd1, 16'h8000);
        repeat (34) send_query(4'd0, 16'h7FFF);
        send_query(4'd1, 16'h8000);

        // random phases, each under its own register setting
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       set_config(5'd16, 5'd16);
                1:       set_config(5'd1, 5'd1);
                2:       set_config(5'd31, 5'd0);
                default: set_config(ncs_pkg::CFG_W'($urandom_range(31)),
                                    ncs_pkg::CFG_W'($urandom_range(31)));
            endcase
            calm = (phase == 3);
            if (phase == 4)
            begin
                hold_req = 1'b1;
            end
            count = 0;
            while (count < 55)
            begin
                roll = $urandom_range(99);
                if (roll < 80)
                begin
                    // well-formed query, components in order
                    for (int d = 0; d < dims_now; d++)
                    begin
                        send_query(ncs_pkg::COMP_W'(d), pick_value());
                    end
                    count += dims_now;
                end
                else if (roll < 90)
                begin
                    send_word(ncs_pkg::REQ_LOAD, ncs_pkg::CELL_W'($urandom),
                              ncs_pkg::COMP_W'($urandom), pick_value());
                    count++;
                end
                else
                begin
                    // stray component: repeat, gap or out of range
                    comp = ncs_pkg::COMP_W'($urandom);
                    send_query(comp, pick_value());
                    if (comp < dims_now)
                    begin
                        count++;
                    end
                end
            end
        end
        calm = 1'b0;

        wait_idle();
        if (fail_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
